### rtl/core/rtpd_pkg.sv
// shared types and constants of the radar tlv point deframer
package rtpd_pkg;

   // frame layout, in bytes
   localparam int MAGIC_LEN        = 8;
   localparam int HEADER_BYTES     = 48;
   localparam int HDR_WORD32_BYTES = 36;
   localparam int TLV_HDR_BYTES    = 8;
   localparam int UNIT_BYTES       = 20;
   localparam int TLV_FIXED_BYTES  = 28;
   localparam int POINT_BYTES      = 8;

   // section byte counter, large enough for the header body
   localparam int CNT_W = 6;

   // magic word, in arrival order
   localparam logic [7:0] MAGIC_SEQ [MAGIC_LEN] = '{
      8'h02, 8'h01, 8'h04, 8'h03, 8'h06, 8'h05, 8'h08, 8'h07
   };

   // record kinds
   localparam logic [2:0] KIND_HEADER = 3'd0;
   localparam logic [2:0] KIND_TLV    = 3'd1;
   localparam logic [2:0] KIND_UNIT   = 3'd2;
   localparam logic [2:0] KIND_POINT  = 3'd3;
   localparam logic [2:0] KIND_ERROR  = 3'd4;

   // error codes
   localparam logic [1:0] ERR_TYPE      = 2'd0;
   localparam logic [1:0] ERR_TOO_LONG  = 2'd1;
   localparam logic [1:0] ERR_TOO_SHORT = 2'd2;

   // control registers
   localparam int          CSR_INDEX_W       = 1;
   localparam int          CSR_DATA_W        = 32;
   localparam logic [0:0]  CSR_EXPECTED_TYPE = 1'b0;
   localparam logic [0:0]  CSR_MAX_LENGTH    = 1'b1;
   localparam logic [31:0] EXPECTED_TYPE_RST = 32'd6;
   localparam logic [15:0] MAX_LENGTH_RST    = 16'd10000;

   // decoupling queue
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // stream widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 120;
   localparam int RSP_USER_W = 3;

   typedef struct packed {
      logic [2:0]         record_kind;
      logic [3:0]         word_index;
      logic [31:0]        word_value;
      logic signed [7:0]  elevation_raw;
      logic signed [7:0]  azimuth_raw;
      logic signed [15:0] doppler_raw;
      logic signed [15:0] range_raw;
      logic signed [15:0] snr_raw;
      logic [12:0]        point_number;
      logic               point_last;
      logic [1:0]         error_code;
   } record_type;

endpackage

### rtl/core/rtpd_parser.sv
// front part: byte parser that hunts the magic word and builds result records
module rtpd_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   byte_valid,
   input  logic [7:0]             rx_byte,
   input  logic [31:0]            expected_tlv_type,
   input  logic [15:0]            max_tlv_length,
   output logic                   rec_valid,
   output rtpd_pkg::record_type   rec
);

   typedef enum logic [4:0] {
      PH_HUNT   = 5'b00001,
      PH_HEADER = 5'b00010,
      PH_TLV    = 5'b00100,
      PH_UNITS  = 5'b01000,
      PH_POINTS = 5'b10000
   } phase_type;

   localparam int CW = rtpd_pkg::CNT_W;
   localparam logic [CW-1:0] C_MAGIC  = CW'(rtpd_pkg::MAGIC_LEN);
   localparam logic [CW-1:0] C_HDR32  = CW'(rtpd_pkg::HDR_WORD32_BYTES);
   localparam logic [CW-1:0] C_HDREND = CW'(rtpd_pkg::HEADER_BYTES - rtpd_pkg::MAGIC_LEN);
   localparam logic [CW-1:0] C_HDR16  = CW'(rtpd_pkg::HDR_WORD32_BYTES + 2);
   localparam logic [CW-1:0] C_TYPE   = CW'(4);
   localparam logic [CW-1:0] C_TLVEND = CW'(rtpd_pkg::TLV_HDR_BYTES);
   localparam logic [CW-1:0] C_UNITS  = CW'(rtpd_pkg::UNIT_BYTES);
   localparam logic [CW-1:0] C_POINT  = CW'(rtpd_pkg::POINT_BYTES);
   localparam logic [31:0]   C_FIXED  = 32'(rtpd_pkg::TLV_FIXED_BYTES);
   localparam logic [3:0]    IDX_HDR16_BASE = 4'(rtpd_pkg::HDR_WORD32_BYTES / 4);

   phase_type      phase_ff, phase_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [63:0]    shift_ff, shift_in;
   logic [12:0]    total_ff, total_in;
   logic [12:0]    remaining_ff, remaining_in;
   logic [12:0]    number_ff, number_in;

   logic [CW-1:0]  cnt_inc;
   logic [CW-1:0]  hdr16_off;
   logic [31:0]    w32;
   logic [15:0]    w16;
   logic [15:0]    len_minus_fixed;

   always_comb begin
      shift_in        = byte_valid ? {rx_byte, shift_ff[63:8]} : shift_ff;
      w32             = shift_in[63:32];
      w16             = shift_in[63:48];
      cnt_inc         = count_ff + CW'(1);
      hdr16_off       = cnt_inc - C_HDR16;
      len_minus_fixed = w32[15:0] - C_FIXED[15:0];

      phase_in     = phase_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      remaining_in = remaining_ff;
      number_in    = number_ff;
      rec_valid    = 1'b0;
      rec          = '0;

      if (byte_valid) begin
         unique case (phase_ff)
            PH_HEADER: begin
               count_in = cnt_inc;
               if (cnt_inc <= C_HDR32) begin
                  if (cnt_inc[1:0] == 2'b00) begin
                     rec_valid       = 1'b1;
                     rec.record_kind = rtpd_pkg::KIND_HEADER;
                     rec.word_index  = cnt_inc[5:2] - 4'd1;
                     rec.word_value  = w32;
                  end
               end else if (!cnt_inc[0]) begin
                  rec_valid       = 1'b1;
                  rec.record_kind = rtpd_pkg::KIND_HEADER;
                  rec.word_index  = IDX_HDR16_BASE + 4'(hdr16_off >> 1);
                  rec.word_value  = {16'd0, w16};
               end
               if (cnt_inc >= C_HDREND) begin
                  phase_in = PH_TLV;
                  count_in = '0;
               end
            end
            PH_TLV: begin
               count_in = cnt_inc;
               if (cnt_inc == C_TYPE) begin
                  rec_valid      = 1'b1;
                  rec.word_value = w32;
                  if (w32 != expected_tlv_type) begin
                     rec.record_kind = rtpd_pkg::KIND_ERROR;
                     rec.error_code  = rtpd_pkg::ERR_TYPE;
                     phase_in        = PH_HUNT;
                     count_in        = '0;
                  end else begin
                     rec.record_kind = rtpd_pkg::KIND_TLV;
                  end
               end else if (cnt_inc >= C_TLVEND) begin
                  rec_valid      = 1'b1;
                  rec.word_value = w32;
                  if (w32 > {16'd0, max_tlv_length}) begin
                     rec.record_kind = rtpd_pkg::KIND_ERROR;
                     rec.error_code  = rtpd_pkg::ERR_TOO_LONG;
                     phase_in        = PH_HUNT;
                     count_in        = '0;
                  end else if (w32 < C_FIXED) begin
                     rec.record_kind = rtpd_pkg::KIND_ERROR;
                     rec.error_code  = rtpd_pkg::ERR_TOO_SHORT;
                     phase_in        = PH_HUNT;
                     count_in        = '0;
                  end else begin
                     rec.record_kind = rtpd_pkg::KIND_TLV;
                     rec.word_index  = 4'd1;
                     total_in        = len_minus_fixed[15:3];
                     phase_in        = PH_UNITS;
                     count_in        = '0;
                  end
               end
            end
            PH_UNITS: begin
               count_in = cnt_inc;
               if (cnt_inc[1:0] == 2'b00) begin
                  rec_valid       = 1'b1;
                  rec.record_kind = rtpd_pkg::KIND_UNIT;
                  rec.word_index  = cnt_inc[5:2] - 4'd1;
                  rec.word_value  = w32;
               end
               if (cnt_inc >= C_UNITS) begin
                  remaining_in = total_ff;
                  number_in    = '0;
                  count_in     = '0;
                  phase_in     = (total_ff == '0) ? PH_HUNT : PH_POINTS;
               end
            end
            PH_POINTS: begin
               if (remaining_ff == '0) begin
                  phase_in = PH_HUNT;
                  count_in = '0;
               end else begin
                  count_in = cnt_inc;
                  if (cnt_inc >= C_POINT) begin
                     rec_valid         = 1'b1;
                     rec.record_kind   = rtpd_pkg::KIND_POINT;
                     rec.elevation_raw = shift_in[7:0];
                     rec.azimuth_raw   = shift_in[15:8];
                     rec.doppler_raw   = shift_in[31:16];
                     rec.range_raw     = shift_in[47:32];
                     rec.snr_raw       = shift_in[63:48];
                     rec.point_number  = number_ff;
                     rec.point_last    = (remaining_ff == 13'd1);
                     remaining_in      = remaining_ff - 13'd1;
                     number_in         = number_ff + 13'd1;
                     count_in          = '0;
                     if (remaining_ff == 13'd1) begin
                        phase_in = PH_HUNT;
                     end
                  end
               end
            end
            default: begin
               // magic hunt; any unused phase code hunts as well
               phase_in = PH_HUNT;
               if (count_ff < C_MAGIC && rx_byte == rtpd_pkg::MAGIC_SEQ[count_ff[2:0]]) begin
                  if (cnt_inc == C_MAGIC) begin
                     phase_in = PH_HEADER;
                     count_in = '0;
                  end else begin
                     count_in = cnt_inc;
                  end
               end else begin
                  count_in = (rx_byte == rtpd_pkg::MAGIC_SEQ[0]) ? CW'(1) : '0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         count_ff     <= '0;
         shift_ff     <= '0;
         total_ff     <= '0;
         remaining_ff <= '0;
         number_ff    <= '0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         shift_ff     <= shift_in;
         total_ff     <= total_in;
         remaining_ff <= remaining_in;
         number_ff    <= number_in;
      end
   end

endmodule

### rtl/core/rtpd_queue.sv
// short record queue between the parser and the output stage
module rtpd_queue #(
   parameter int DEPTH = rtpd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rtpd_pkg::record_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 empty,
   output rtpd_pkg::record_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rtpd_pkg::record_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/core/rtpd_emitter.sv
// back part: output register that drains the queue onto the result stream
module rtpd_emitter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_empty,
   input  rtpd_pkg::record_type                q_data,
   output logic                                q_pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rtpd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [rtpd_pkg::RSP_USER_W-1:0]     rsp_tuser,
   output logic                                rsp_tlast
);

   rtpd_pkg::record_type rec_ff;
   logic                 valid_ff, valid_in;
   logic                 load;

   assign load     = !q_empty && (!valid_ff || rsp_tready);
   assign q_pop    = load;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (load) begin
         rec_ff <= q_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = rec_ff.record_kind;
   assign rsp_tlast  = rec_ff.point_last;
   assign rsp_tdata  = {5'd0,
                        rec_ff.error_code,
                        rec_ff.point_number,
                        rec_ff.snr_raw,
                        rec_ff.range_raw,
                        rec_ff.doppler_raw,
                        rec_ff.azimuth_raw,
                        rec_ff.elevation_raw,
                        rec_ff.word_value,
                        rec_ff.word_index};

endmodule

### rtl/core/radar_tlv_point_deframer.sv
// top level of the radar tlv point deframer
// takes one serial-link byte per req beat, hunts for the magic word
// 02 01 04 03 06 05 08 07 and resyncs on any mismatch, then reports the rest
// of the frame header (nine 32-bit and two 16-bit little-endian words), the
// tlv type and length words (checked against csr limits), five raw unit words
// and one record per 8-byte point. a failed tlv check gives one error record
// and the hunt starts over. throughput is one byte per clock while req_tready
// is high: the parser takes a byte every such cycle and pushes at most one
// record, a short queue decouples it from the output register, and a record
// goes through the queue and the output register on its way to rsp. req_tready
// only drops when the queue is full because the rsp side is stalled.
module radar_tlv_point_deframer #(
   parameter int QUEUE_DEPTH = rtpd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [rtpd_pkg::REQ_DATA_W-1:0]       req_tdata,   // [7:0] rx_byte
   // result stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [3:0] word_index, [35:4] word_value, [43:36] elevation_raw,
   // [51:44] azimuth_raw, [67:52] doppler_raw, [83:68] range_raw,
   // [99:84] snr_raw, [112:100] point_number, [114:113] error_code, rest zero
   output logic [rtpd_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic [rtpd_pkg::RSP_USER_W-1:0]       rsp_tuser,   // [2:0] record_kind
   output logic                                  rsp_tlast,   // point_last
   // control register writes
   input  logic                                  csr_we,
   input  logic [rtpd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [rtpd_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   // control registers
   logic [31:0] expected_type_ff, expected_type_in;
   logic [15:0] max_length_ff, max_length_in;

   always_comb begin
      expected_type_in = expected_type_ff;
      max_length_in    = max_length_ff;
      if (csr_we) begin
         case (csr_index)
            rtpd_pkg::CSR_EXPECTED_TYPE: expected_type_in = csr_wdata;
            rtpd_pkg::CSR_MAX_LENGTH:    max_length_in    = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_type_ff <= rtpd_pkg::EXPECTED_TYPE_RST;
         max_length_ff    <= rtpd_pkg::MAX_LENGTH_RST;
      end else begin
         expected_type_ff <= expected_type_in;
         max_length_ff    <= max_length_in;
      end
   end

   // a byte beat is taken whenever the queue has room
   logic                 q_full, q_empty, q_pop;
   logic                 byte_beat;
   logic                 rec_valid;
   rtpd_pkg::record_type rec, q_data;

   assign req_tready = !q_full;
   assign byte_beat  = req_tvalid && req_tready;

   rtpd_parser u_parser (
      .clock             (clock),
      .reset             (reset),
      .byte_valid        (byte_beat),
      .rx_byte           (req_tdata),
      .expected_tlv_type (expected_type_ff),
      .max_tlv_length    (max_length_ff),
      .rec_valid         (rec_valid),
      .rec               (rec)
   );

   rtpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_valid),
      .push_data (rec),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_data)
   );

   rtpd_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
